### src/dtf_pkg.sv
// Shared widths, register indexes and the divisor table for the decimal to float32 converter.
package dtf_pkg;

   // Field widths
   localparam int IP_W    = 20;
   localparam int FN_W    = 10;
   localparam int SEL_W   = 2;
   localparam int DEC_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int FLOAT_W = 32;
   localparam int EXP_W   = 8;
   localparam int MANT_W  = 23;
   localparam int CNT_W   = 5;

   // Exponent bias and default integer range
   localparam int EXP_BIAS     = 127;
   localparam int INT_BITS_DEF = 20;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRICE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 2'd2;

   // Scale selector codes (any other code uses the volume setting)
   localparam logic [SEL_W-1:0] SEL_PRICE = 2'd0;
   localparam logic [SEL_W-1:0] SEL_ALT   = 2'd1;

   // Decimal places setting to divisor 10^k
   function automatic logic [FN_W-1:0] divisor_of(input logic [DEC_W-1:0] places);
      logic [FN_W-1:0] d;
      case (places)
         2'd0:    d = 10'd1;
         2'd1:    d = 10'd10;
         2'd2:    d = 10'd100;
         default: d = 10'd1000;
      endcase
      return d;
   endfunction

endpackage

### src/decimal_to_float32_converter.sv
// Top level: bit-serial conversion of a fixed decimal value to an IEEE-754 single pattern.
//
//   channel  ports                                   direction  flow
//   input    start, busy, req_*                      in         accepted on start && !busy
//   result   rsp_strobe, rsp_*                       out        one-cycle strobe, no stall
//   config   csr_we, csr_index, csr_wdata            in         write on csr_we, no wait
//
// One value bit is produced per cycle, MSB first: the integer bits from a shift
// register, then the fraction bits from a one-bit-per-cycle restoring divider.
// Nonzero integer part with leading one at p: the W-1-p zeros above it, the hidden one,
// the 23 mantissa bits, then the done state, W = min(INT_BITS, 20). Zero integer part:
// scanning starts at the fraction bits. Invalid or zero inputs: the strobe in the cycle
// right after the accept. Reset clears control state and the three settings; the
// receiver cannot stall, so the result leaves on time.
module decimal_to_float32_converter
   import dtf_pkg::*;
#(
   parameter int INT_BITS = INT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // command
   input  logic                 start,
   output logic                 busy,
   input  logic [IP_W-1:0]      req_integer_part,
   input  logic [FN_W-1:0]      req_fraction_numerator,
   input  logic [SEL_W-1:0]     req_scale_select,
   // result
   output logic                 rsp_strobe,
   output logic [FLOAT_W-1:0]   rsp_float_bits,
   output logic                 rsp_invalid,
   // settings
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DEC_W-1:0]     csr_wdata
);

   // Integer bits actually scanned
   localparam int IW    = (INT_BITS < IP_W) ? INT_BITS : IP_W;
   localparam int ICNT_W = $clog2(IW);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_INT  = 4'b0010,
      S_FRAC = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [DEC_W-1:0]   price_ff, price_in;
   logic [DEC_W-1:0]   alt_ff, alt_in;
   logic [DEC_W-1:0]   volume_ff, volume_in;
   logic [IW-1:0]      int_ff, int_in;
   logic [ICNT_W-1:0]  icnt_ff, icnt_in;
   logic [FN_W-1:0]    rem_ff, rem_in;
   logic [FN_W-1:0]    div_ff, div_in;
   logic [EXP_W-1:0]   pos_ff, pos_in;
   logic [MANT_W-1:0]  mant_ff, mant_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               found_ff, found_in;
   logic               inv_ff, inv_in;

   logic               accept;
   logic [DEC_W-1:0]   places;
   logic [FN_W-1:0]    sel_div;
   logic               int_over;
   logic               bad;
   logic [FN_W:0]      twice_rem;
   logic               div_bit;
   logic               bit_now;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Settings writes; index 3 is ignored
   always_comb begin
      price_in  = price_ff;
      alt_in    = alt_ff;
      volume_in = volume_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRICE:  price_in  = csr_wdata;
            CSR_ALT:    alt_in    = csr_wdata;
            CSR_VOLUME: volume_in = csr_wdata;
            default:    ;
         endcase
      end
   end

   // Divisor selection and input checks
   always_comb begin
      case (req_scale_select)
         SEL_PRICE: places = price_ff;
         SEL_ALT:   places = alt_ff;
         default:   places = volume_ff;
      endcase
      sel_div  = divisor_of(places);
      int_over = ((req_integer_part >> IW) != '0);
      bad      = int_over || (req_fraction_numerator >= sel_div);
   end

   // One restoring-division step
   always_comb begin
      twice_rem = {rem_ff, 1'b0};
      div_bit   = (twice_rem >= {1'b0, div_ff});
      bit_now   = (state_ff == S_INT) ? int_ff[IW-1] : div_bit;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      int_in   = int_ff;
      icnt_in  = icnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      pos_in   = pos_ff;
      mant_in  = mant_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      inv_in   = inv_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               int_in   = req_integer_part[IW-1:0];
               icnt_in  = ICNT_W'(IW - 1);
               rem_in   = req_fraction_numerator;
               div_in   = sel_div;
               mant_in  = '0;
               cnt_in   = '0;
               found_in = 1'b0;
               inv_in   = bad;
               if (bad || (req_integer_part == '0 && req_fraction_numerator == '0)) begin
                  pos_in   = '0;
                  state_in = S_DONE;
               end else if (req_integer_part != '0) begin
                  pos_in   = EXP_W'(EXP_BIAS + IW - 1);
                  state_in = S_INT;
               end else begin
                  pos_in   = EXP_W'(EXP_BIAS - 1);
                  state_in = S_FRAC;
               end
            end
         end
         S_INT, S_FRAC: begin
            // consume one value bit
            if (state_ff == S_INT) begin
               int_in  = {int_ff[IW-2:0], 1'b0};
               icnt_in = icnt_ff - 1'b1;
               if (icnt_ff == '0) begin
                  state_in = S_FRAC;
               end
            end else begin
               rem_in = div_bit ? FN_W'(twice_rem - {1'b0, div_ff}) : twice_rem[FN_W-1:0];
            end
            if (!found_ff) begin
               // hidden leading one fixes the exponent
               if (bit_now) begin
                  found_in = 1'b1;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end else begin
               mant_in = {mant_ff[MANT_W-2:0], bit_now};
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MANT_W - 1)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         price_ff  <= '0;
         alt_ff    <= '0;
         volume_ff <= '0;
      end else begin
         state_ff  <= state_in;
         price_ff  <= price_in;
         alt_ff    <= alt_in;
         volume_ff <= volume_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      int_ff   <= int_in;
      icnt_ff  <= icnt_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      pos_ff   <= pos_in;
      mant_ff  <= mant_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      inv_ff   <= inv_in;
   end

   assign rsp_strobe     = (state_ff == S_DONE);
   assign rsp_float_bits = {1'b0, pos_ff, mant_ff};
   assign rsp_invalid    = inv_ff;

endmodule

### src/dtf_checker.sv
// Port-level checks for the decimal to float32 converter, bound to the top level.
module dtf_checker
   import dtf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [FLOAT_W-1:0] rsp_float_bits,
   input logic               rsp_invalid
);

   // an accepted command keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after start");

   // a result beat only comes while busy and is never repeated
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 (!rsp_strobe && !busy))
      else $error("result beat outside a command or repeated");

   // invalid results carry zero bits
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_invalid |-> rsp_float_bits == '0)
      else $error("invalid result with nonzero bits");

   // values are never negative
   a_sign_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_float_bits[FLOAT_W-1])
      else $error("sign bit set");

endmodule

bind decimal_to_float32_converter dtf_checker u_dtf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_float_bits (rsp_float_bits),
   .rsp_invalid    (rsp_invalid)
);

### dv/decimal_to_float32_converter_tb.sv
// Self-checking testbench for the decimal to float32 converter: directed and random conversions.
`timescale 1ns / 1ps

module decimal_to_float32_converter_tb;
   import dtf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 90;
   localparam int FRAC_SHIFT  = 40;
   localparam int DRAIN_WAIT  = 60;

   // Codes the package leaves unnamed
   localparam logic [SEL_W-1:0]     SEL_VOL   = 2'd2;
   localparam logic [SEL_W-1:0]     SEL_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [FLOAT_W-1:0] float_bits;
      logic               invalid;
   } conv_result_type;

   // Scoreboard: shadow settings, conversion predictor, queue of due results
   class conv_scoreboard;
      logic [DEC_W-1:0] price_dec;
      logic [DEC_W-1:0] alt_dec;
      logic [DEC_W-1:0] vol_dec;
      conv_result_type  due_results [$];
      int               errors;

      function new();
         price_dec = '0;
         alt_dec   = '0;
         vol_dec   = '0;
         errors    = 0;
      endfunction

      function void note_write(logic [CSR_IDX_W-1:0] idx, logic [DEC_W-1:0] val);
         case (idx)
            CSR_PRICE:  price_dec = val;
            CSR_ALT:    alt_dec   = val;
            CSR_VOLUME: vol_dec   = val;
            default: ;
         endcase
      endfunction

      function logic [DEC_W-1:0] places_for(logic [SEL_W-1:0] sel);
         if (sel == SEL_PRICE)
            return price_dec;
         else if (sel == SEL_ALT)
            return alt_dec;
         return vol_dec;
      endfunction

      function int divisor(logic [DEC_W-1:0] k);
         int d;
         d = 1;
         repeat (k) d = d * 10;
         return d;
      endfunction

      function int top_one(logic [63:0] v);
         int pos;
         pos = 0;
         for (int i = 0; i < 64; i++)
            if (v[i]) pos = i;
         return pos;
      endfunction

      // Truncating conversion of ip + fn / 10^k to single-precision bits
      function conv_result_type to_float32(logic [IP_W-1:0] ip, logic [FN_W-1:0] fn,
                                           logic [SEL_W-1:0] sel);
         logic [63:0]     div;
         logic [63:0]     q;
         logic [63:0]     mant;
         int              lead;
         conv_result_type r;
         div = 64'(divisor(places_for(sel)));
         r   = '0;
         if (64'(fn) >= div) begin
            r.invalid = 1'b1;
         end else if (ip != '0) begin
            lead = top_one(64'(ip));
            q    = (64'(ip) << MANT_W) + ((64'(fn) << MANT_W) / div);
            mant = q >> lead;
            r.float_bits = {1'b0, 8'(EXP_BIAS + lead), mant[MANT_W-1:0]};
         end else if (fn != '0) begin
            // pure fraction: leading one lies below the binary point
            q    = (64'(fn) << FRAC_SHIFT) / div;
            lead = top_one(q);
            mant = q >> (lead - MANT_W);
            r.float_bits = {1'b0, 8'(EXP_BIAS + lead - FRAC_SHIFT), mant[MANT_W-1:0]};
         end
         return r;
      endfunction

      function void note_item(logic [IP_W-1:0] ip, logic [FN_W-1:0] fn,
                              logic [SEL_W-1:0] sel);
         due_results.push_back(to_float32(ip, fn, sel));
      endfunction

      function void check_result(logic [FLOAT_W-1:0] bits, logic inv);
         conv_result_type exp_r;
         if (due_results.size() == 0) begin
            $error("unexpected result beat: float_bits %h invalid %b", bits, inv);
            errors++;
            return;
         end
         exp_r = due_results.pop_front();
         if (bits !== exp_r.float_bits) begin
            $error("float_bits mismatch: expected %h, got %h", exp_r.float_bits, bits);
            errors++;
         end
         if (inv !== exp_r.invalid) begin
            $error("invalid mismatch: expected %b, got %b", exp_r.invalid, inv);
            errors++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset                  = 1'b1;
   logic                 start                  = 1'b0;
   logic                 busy;
   logic [IP_W-1:0]      req_integer_part       = '0;
   logic [FN_W-1:0]      req_fraction_numerator = '0;
   logic [SEL_W-1:0]     req_scale_select       = '0;
   logic                 rsp_strobe;
   logic [FLOAT_W-1:0]   rsp_float_bits;
   logic                 rsp_invalid;
   logic                 csr_we                 = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index              = '0;
   logic [DEC_W-1:0]     csr_wdata              = '0;
   int                   cycles                 = 0;

   conv_scoreboard sb = new();

   decimal_to_float32_converter u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_integer_part       (req_integer_part),
      .req_fraction_numerator (req_fraction_numerator),
      .req_scale_select       (req_scale_select),
      .rsp_strobe             (rsp_strobe),
      .rsp_float_bits         (rsp_float_bits),
      .rsp_invalid            (rsp_invalid),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Monitor: settings writes, accepted commands, result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.note_write(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_item(req_integer_part, req_fraction_numerator, req_scale_select);
         if (rsp_strobe)
            sb.check_result(rsp_float_bits, rsp_invalid);
      end
   end

   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) < pct)
         return $urandom_range(1, 11);
      return 0;
   endfunction

   // Present one command, optionally after an idle burst, and hold it until taken
   task automatic send_item(logic [IP_W-1:0] ip, logic [FN_W-1:0] fn,
                            logic [SEL_W-1:0] sel, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                  <= 1'b1;
      req_integer_part       <= ip;
      req_fraction_numerator <= fn;
      req_scale_select       <= sel;
      do @(posedge clock); while (busy);
   endtask

   // Stop issuing and wait until every due result has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write all three settings, plus a write to the unused index that must be ignored
   task automatic write_settings(logic [DEC_W-1:0] p, logic [DEC_W-1:0] a,
                                 logic [DEC_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRICE;
      csr_wdata <= p;
      @(posedge clock);
      csr_index <= CSR_ALT;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= CSR_VOLUME;
      csr_wdata <= v;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= DEC_W'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item(int pct);
      logic [IP_W-1:0]  ip;
      logic [FN_W-1:0]  fn;
      logic [SEL_W-1:0] sel;
      int               div;
      sel = SEL_W'($urandom);
      div = sb.divisor(sb.places_for(sel));
      case ($urandom_range(0, 5))
         0: ip = IP_W'($urandom);
         1: ip = IP_W'($urandom_range(0, 15));
         2: ip = '0;
         3: ip = IP_W'((1 << $urandom_range(0, IP_W - 1)) - $urandom_range(0, 1));
         4: ip = IP_W'($urandom_range(0, 1023));
         default: ip = {IP_W{1'b1}} - IP_W'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 9))
         0: fn = FN_W'($urandom);
         1: fn = FN_W'(div);
         2: fn = FN_W'(div - 1);
         default: fn = FN_W'($urandom_range(0, div - 1));
      endcase
      send_item(ip, fn, sel, pick_gap(pct));
   endtask

   initial begin
      int pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings (no decimals): zero, extremes, nonzero fraction invalid
      send_item('0, '0, SEL_PRICE, pick_gap(30));
      send_item({IP_W{1'b1}}, '0, SEL_ALT, pick_gap(30));
      send_item(IP_W'(1), '0, SEL_VOL, pick_gap(30));
      send_item('0, FN_W'(1), SEL_PRICE, pick_gap(30));
      send_item(IP_W'(5), {FN_W{1'b1}}, SEL_SPARE, pick_gap(30));
      drain();

      // Directed, mixed decimals: smallest fractions, divisor boundaries, spare selector
      write_settings(2'd3, 2'd2, 2'd1);
      send_item('0, FN_W'(1), SEL_PRICE, pick_gap(30));
      send_item('0, FN_W'(999), SEL_PRICE, pick_gap(30));
      send_item('0, FN_W'(1000), SEL_PRICE, pick_gap(30));
      send_item('0, {FN_W{1'b1}}, SEL_PRICE, pick_gap(30));
      send_item({IP_W{1'b1}}, FN_W'(999), SEL_PRICE, pick_gap(30));
      send_item(IP_W'(1), FN_W'(999), SEL_PRICE, pick_gap(30));
      send_item('0, FN_W'(99), SEL_ALT, pick_gap(30));
      send_item('0, FN_W'(100), SEL_ALT, pick_gap(30));
      send_item(IP_W'(20'h80000), FN_W'(50), SEL_ALT, pick_gap(30));
      send_item('0, FN_W'(9), SEL_VOL, pick_gap(30));
      send_item('0, FN_W'(10), SEL_VOL, pick_gap(30));
      send_item(IP_W'(7), FN_W'(5), SEL_SPARE, pick_gap(30));
      send_item('0, '0, SEL_VOL, pick_gap(30));
      send_item(IP_W'(20'h55555), FN_W'(10'h155), SEL_PRICE, pick_gap(30));
      send_item(IP_W'(20'hAAAAA), FN_W'(10'h2AA), SEL_PRICE, pick_gap(30));
      drain();

      // Random phases, each under its own settings; the last one runs without idling
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: write_settings(2'd3, 2'd3, 2'd3);
            1: write_settings(2'd0, 2'd0, 2'd0);
            default: write_settings(DEC_W'($urandom), DEC_W'($urandom), DEC_W'($urandom));
         endcase
         pct = (ph == PHASES - 1) ? 0 : 30 * $urandom_range(0, 2);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_item(pct);
         drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### decimal_to_float32_converter.f
src/dtf_pkg.sv
src/decimal_to_float32_converter.sv
src/dtf_checker.sv
dv/decimal_to_float32_converter_tb.sv
